// ===== src/clp_pkg.sv =====
// Shared types, character codes and field limits for the cron line parser.
`default_nettype none

package clp_pkg;

   localparam int unsigned LINE_LENGTH_DEF = 1024;
   localparam int unsigned NUM_FIELDS      = 5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0]  SEP_MAX   = 3'd4;
   localparam logic [6:0]  VALUE_MAX = 7'd127;
   localparam logic [9:0]  OUT_MAX   = 10'd1023;
   localparam logic [10:0] DEC_BASE  = 11'd10;

   localparam logic [6:0] FIELD_LO [NUM_FIELDS] = '{7'd0, 7'd0, 7'd1, 7'd1, 7'd0};
   localparam logic [6:0] FIELD_HI [NUM_FIELDS] = '{7'd59, 7'd23, 7'd31, 7'd12, 7'd6};

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SCHED,
      PH_CMD,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      FK_EMPTY,
      FK_WILD,
      FK_DIGITS,
      FK_BAD
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SKIPPED,
      ST_NO_PIPE,
      ST_NO_CMD,
      ST_FEW_FIELDS,
      ST_EMPTY_FIELD,
      ST_BAD_DIGIT,
      ST_RANGE
   } status_type;

   // Result word, lowest field last.
   typedef struct packed {
      logic [1:0] pad;
      logic [9:0] command_length;
      logic [9:0] command_start;
      logic [4:0] any_mask;
      logic [2:0] weekday_val;
      logic [3:0] month_val;
      logic [4:0] day_val;
      logic [4:0] hour_val;
      logic [5:0] minute_val;
      logic [2:0] error_field;
      status_type status;
   } result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

`default_nettype wire

// ===== src/cron_line_parser.sv =====
// Cron schedule line parser: one character per transaction, one result per line.
//
// Usage:
//   req_* carries one character per transaction: req_tdata is the byte, req_tuser
//   says whether the byte is present (low lets an empty line end) and req_tlast
//   marks the last transaction of the line. rsp_* carries one result per line:
//   status, field at fault, the five parsed values, the wildcard mask and the
//   trimmed command's offset and length.
//   The line's last transaction passes the input register, then the result
//   register; it waits in the input register while an earlier result is held.
//   Throughput: one character per cycle, lines back to back, unless a result is
//   still waiting at a line end; the parse state is one small update per character.
//   Reset clears the input stage, the parse state and the result valid flag;
//   a line in progress is dropped.
//   When the receiver stalls, the result is held and characters keep flowing;
//   req_tready drops only when a further line end reaches the parse stage
//   while the previous result is still waiting.
`default_nettype none

module cron_line_parser
   import clp_pkg::*;
#(
   parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tuser,   // [0] has_char
   input  wire logic        req_tlast,   // line_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // status, error_field, minute_val, hour_val,
                                         // day_val, month_val, weekday_val, any_mask,
                                         // command_start, command_length, zero pad
);

   localparam int unsigned POS_W = $clog2(LINE_LENGTH);
   localparam int unsigned CW    = (POS_W + 1 > 11) ? POS_W + 1 : 11;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LENGTH - 1);

   // input stage
   logic             s1_valid_ff;
   logic [7:0]       s1_ch_ff;
   logic             s1_has_ff;
   logic             s1_last_ff;
   logic             adv;

   // parse state
   phase_type        phase_ff, phase_up, phase_in;
   logic [POS_W-1:0] pos_ff, pos_up, pos_in;
   logic [2:0]       sep_ff, sep_up, sep_in;
   logic [2:0]       saved_ff, saved_up, saved_in;
   logic             ws_ff, ws_up, ws_in;
   logic             pipe_ff, pipe_up, pipe_in;
   logic [POS_W-1:0] first_ff, first_up, first_in;
   logic [POS_W-1:0] last_ff, last_up, last_in;
   logic             cmd_ne_ff, cmd_ne_up, cmd_ne_in;
   kind_type         kind_ff [NUM_FIELDS];
   kind_type         kind_up [NUM_FIELDS];
   kind_type         kind_in [NUM_FIELDS];
   logic [6:0]       value_ff [NUM_FIELDS];
   logic [6:0]       value_up [NUM_FIELDS];
   logic [6:0]       value_in [NUM_FIELDS];
   logic             trail_ff [NUM_FIELDS];
   logic             trail_up [NUM_FIELDS];
   logic             trail_in [NUM_FIELDS];
   logic [10:0]      acc [NUM_FIELDS];

   logic             blank;
   logic [3:0]       digit;
   logic             sched_go;
   logic             ft_go;

   // result
   result_type       rsp_ff, res;
   logic             rsp_valid_ff;
   status_type       st;
   logic [2:0]       ef;
   logic [4:0]       mask;
   logic [6:0]       vals [NUM_FIELDS];
   logic             stop;
   logic [CW-1:0]    cs_w;
   logic [CW-1:0]    cl_w;

   assign adv        = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign blank = is_blank(s1_ch_ff);
   assign digit = 4'(s1_ch_ff - CH_ZERO);

   for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_acc
      assign acc[g] = 11'(value_ff[g]) * DEC_BASE + 11'(digit);
   end

   // Phase sequencing.
   always_comb begin
      phase_up = phase_ff;
      if (s1_has_ff) begin
         case (phase_ff)
            PH_LEAD: begin
               if (blank) begin
                  phase_up = PH_LEAD;
               end else if (s1_ch_ff == CH_HASH) begin
                  phase_up = PH_SKIP;
               end else if (s1_ch_ff == CH_PIPE) begin
                  phase_up = PH_CMD;
               end else begin
                  phase_up = PH_SCHED;
               end
            end
            PH_SCHED: begin
               if (s1_ch_ff == CH_PIPE) begin
                  phase_up = PH_CMD;
               end
            end
            default: begin
               phase_up = phase_ff;
            end
         endcase
      end
   end

   assign sched_go = s1_has_ff &&
                     ((phase_ff == PH_LEAD && !blank && s1_ch_ff != CH_HASH &&
                       s1_ch_ff != CH_PIPE) || phase_ff == PH_SCHED);

   // Character update of the schedule, fields and command span.
   always_comb begin
      pos_up    = pos_ff;
      sep_up    = sep_ff;
      saved_up  = saved_ff;
      ws_up     = ws_ff;
      pipe_up   = pipe_ff;
      first_up  = first_ff;
      last_up   = last_ff;
      cmd_ne_up = cmd_ne_ff;
      ft_go     = 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         kind_up[i]  = kind_ff[i];
         value_up[i] = value_ff[i];
         trail_up[i] = trail_ff[i];
      end

      if (s1_has_ff && pos_ff != POS_LAST) begin
         pos_up = pos_ff + POS_W'(1);
      end
      if (s1_has_ff && phase_ff == PH_LEAD && s1_ch_ff == CH_PIPE) begin
         pipe_up = 1'b1;
      end

      if (sched_go) begin
         if (s1_ch_ff == CH_PIPE) begin
            // spaces just before the pipe are not separators
            if (ws_ff) begin
               sep_up = saved_ff;
            end
            ws_up   = 1'b0;
            pipe_up = 1'b1;
         end else if (blank) begin
            if (!ws_ff) begin
               saved_up = sep_ff;
               ws_up    = 1'b1;
            end
            if (s1_ch_ff == CH_SPACE && sep_ff < SEP_MAX) begin
               sep_up = sep_ff + 3'd1;
            end else begin
               ft_go = 1'b1;
            end
         end else begin
            ws_up = 1'b0;
            ft_go = 1'b1;
         end
      end

      if (s1_has_ff && phase_ff == PH_CMD && !blank) begin
         if (!cmd_ne_ff) begin
            first_up  = pos_ff;
            cmd_ne_up = 1'b1;
         end
         last_up = pos_ff;
      end

      for (int i = 0; i < NUM_FIELDS; i++) begin
         if (ft_go && sep_ff == 3'(i)) begin
            if (blank) begin
               if (kind_ff[i] != FK_EMPTY) begin
                  trail_up[i] = 1'b1;
               end
            end else if (trail_ff[i]) begin
               kind_up[i] = FK_BAD;
            end else begin
               case (kind_ff[i])
                  FK_EMPTY: begin
                     if (s1_ch_ff == CH_STAR || s1_ch_ff == CH_QUERY) begin
                        kind_up[i] = FK_WILD;
                     end else if (is_digit(s1_ch_ff)) begin
                        kind_up[i]  = FK_DIGITS;
                        value_up[i] = 7'(digit);
                     end else begin
                        kind_up[i] = FK_BAD;
                     end
                  end
                  FK_DIGITS: begin
                     if (is_digit(s1_ch_ff)) begin
                        value_up[i] = (acc[i] > 11'(VALUE_MAX)) ? VALUE_MAX : acc[i][6:0];
                     end else begin
                        kind_up[i] = FK_BAD;
                     end
                  end
                  default: begin
                     kind_up[i] = FK_BAD;
                  end
               endcase
            end
         end
      end
   end

   // Clear the parse state once the line ends.
   always_comb begin
      phase_in  = s1_last_ff ? PH_LEAD : phase_up;
      pos_in    = s1_last_ff ? '0 : pos_up;
      sep_in    = s1_last_ff ? '0 : sep_up;
      saved_in  = s1_last_ff ? '0 : saved_up;
      ws_in     = s1_last_ff ? 1'b0 : ws_up;
      pipe_in   = s1_last_ff ? 1'b0 : pipe_up;
      first_in  = s1_last_ff ? '0 : first_up;
      last_in   = s1_last_ff ? '0 : last_up;
      cmd_ne_in = s1_last_ff ? 1'b0 : cmd_ne_up;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         kind_in[i]  = s1_last_ff ? FK_EMPTY : kind_up[i];
         value_in[i] = s1_last_ff ? '0 : value_up[i];
         trail_in[i] = s1_last_ff ? 1'b0 : trail_up[i];
      end
   end

   // Line verdict.
   always_comb begin
      st    = ST_OK;
      ef    = '0;
      mask  = '0;
      stop  = 1'b0;
      cs_w  = CW'(first_up);
      cl_w  = CW'(last_up) - CW'(first_up) + CW'(1);
      for (int i = 0; i < NUM_FIELDS; i++) begin
         vals[i] = '0;
      end
      res   = '0;

      if (phase_up == PH_LEAD || phase_up == PH_SKIP) begin
         st = ST_SKIPPED;
      end else if (!pipe_up) begin
         st = ST_NO_PIPE;
      end else if (!cmd_ne_up) begin
         st = ST_NO_CMD;
      end else begin
         res.command_start  = (cs_w > CW'(OUT_MAX)) ? OUT_MAX : cs_w[9:0];
         res.command_length = (cl_w > CW'(OUT_MAX)) ? OUT_MAX : cl_w[9:0];
         if (sep_up < SEP_MAX) begin
            st = ST_FEW_FIELDS;
         end else begin
            // first failing field wins
            for (int i = 0; i < NUM_FIELDS; i++) begin
               if (!stop) begin
                  if (kind_up[i] == FK_WILD) begin
                     mask[i] = 1'b1;
                  end else if (kind_up[i] == FK_EMPTY) begin
                     st   = ST_EMPTY_FIELD;
                     ef   = 3'(i);
                     stop = 1'b1;
                  end else if (kind_up[i] == FK_BAD) begin
                     st   = ST_BAD_DIGIT;
                     ef   = 3'(i);
                     stop = 1'b1;
                  end else if (value_up[i] < FIELD_LO[i] || value_up[i] > FIELD_HI[i]) begin
                     st   = ST_RANGE;
                     ef   = 3'(i);
                     stop = 1'b1;
                  end else begin
                     vals[i] = value_up[i];
                  end
               end
            end
         end
      end

      res.status      = st;
      res.error_field = ef;
      if (st == ST_OK) begin
         res.any_mask    = mask;
         res.minute_val  = vals[0][5:0];
         res.hour_val    = vals[1][4:0];
         res.day_val     = vals[2][4:0];
         res.month_val   = vals[3][3:0];
         res.weekday_val = vals[4][2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LEAD;
         pos_ff       <= '0;
         sep_ff       <= '0;
         saved_ff     <= '0;
         ws_ff        <= 1'b0;
         pipe_ff      <= 1'b0;
         first_ff     <= '0;
         last_ff      <= '0;
         cmd_ne_ff    <= 1'b0;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            kind_ff[i]  <= FK_EMPTY;
            value_ff[i] <= '0;
            trail_ff[i] <= 1'b0;
         end
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (adv) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            sep_ff    <= sep_in;
            saved_ff  <= saved_in;
            ws_ff     <= ws_in;
            pipe_ff   <= pipe_in;
            first_ff  <= first_in;
            last_ff   <= last_in;
            cmd_ne_ff <= cmd_ne_in;
            for (int i = 0; i < NUM_FIELDS; i++) begin
               kind_ff[i]  <= kind_in[i];
               value_ff[i] <= value_in[i];
               trail_ff[i] <= trail_in[i];
            end
         end
         if (adv && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_ch_ff   <= req_tdata;
         s1_has_ff  <= req_tuser;
         s1_last_ff <= req_tlast;
      end
      if (adv && s1_last_ff) begin
         rsp_ff <= res;
      end
   end

   a_err_field_only_on_field_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(rsp_ff.status == ST_EMPTY_FIELD || rsp_ff.status == ST_BAD_DIGIT ||
                        rsp_ff.status == ST_RANGE)
      |-> rsp_ff.error_field == '0)
      else $error("error_field set without a field fault");

   a_values_clear_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK
      |-> rsp_ff.any_mask == '0 && rsp_ff.minute_val == '0 && rsp_ff.hour_val == '0 &&
          rsp_ff.day_val == '0 && rsp_ff.month_val == '0 && rsp_ff.weekday_val == '0)
      else $error("values reported for a failed line");

   a_ok_has_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_OK |-> rsp_ff.command_length != '0)
      else $error("accepted line with empty command");

   a_state_cleared_after_line: assert property (@(posedge clock) disable iff (reset)
      adv && s1_last_ff
      |=> phase_ff == PH_LEAD && pos_ff == '0 && !pipe_ff && !cmd_ne_ff && sep_ff == '0)
      else $error("parse state not cleared after line end");

   a_stall_only_on_blocked_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
